>>> design/radar_measurement_jacobian_core_defines.svh
// assertion macros for the radar jacobian core
`ifndef RADAR_MEASUREMENT_JACOBIAN_CORE_DEFINES_SVH
`define RADAR_MEASUREMENT_JACOBIAN_CORE_DEFINES_SVH

// same-cycle implication
`define RMJ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rmj assertion failed");

// next-cycle implication
`define RMJ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rmj assertion failed");

`endif

>>> design/rmj_pkg.sv
package rmj_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned NORM_W = 64;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic valid;
    logic ovf;
  } div_ctl_t;

  function automatic word_t sat_word(input word_t mag, input logic ovf, input logic neg);
    word_t res;
    if (neg) begin
      if (ovf || mag > {1'b1, {(WORD_W-1){1'b0}}}) begin
        res = {1'b1, {(WORD_W-1){1'b0}}};
      end else begin
        res = -mag;
      end
    end else begin
      if (ovf || mag[WORD_W-1]) begin
        res = {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
        res = mag;
      end
    end
    return res;
  endfunction

endpackage

>>> design/rmj_div_cell.sv
module rmj_div_cell import rmj_pkg::*; #(
  parameter int unsigned QB     = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  div_ctl_t          ctl_i,
  input  logic [NORM_W-1:0] den_i,
  input  logic [NORM_W-1:0] rem_i,
  input  logic [QB-1:0]     low_i,
  input  logic [SIDE_W-1:0] side_i,
  output div_ctl_t          ctl_o,
  output logic [NORM_W-1:0] den_o,
  output logic [NORM_W-1:0] rem_o,
  output logic [QB-1:0]     low_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [NORM_W:0]   trial;
  logic              ge;
  logic [NORM_W-1:0] rem_d, rem_q, den_q;
  logic [QB-1:0]     low_d, low_q;
  logic [SIDE_W-1:0] side_q;
  div_ctl_t          ctl_q;

  assign trial = {rem_i, low_i[QB-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign rem_d = ge ? NORM_W'(trial - {1'b0, den_i}) : trial[NORM_W-1:0];
  assign low_d = {low_i[QB-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_q  <= den_i;
      rem_q  <= rem_d;
      low_q  <= low_d;
      side_q <= side_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign den_o  = den_q;
  assign rem_o  = rem_q;
  assign low_o  = low_q;
  assign side_o = side_q;

endmodule

>>> design/rmj_divider.sv
module rmj_divider import rmj_pkg::*; #(
  parameter int unsigned NUM_W  = 64,
  parameter int unsigned QB     = 32,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [NORM_W-1:0] den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic              ovf_o,
  output logic [QB-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned HI_W  = NUM_W - QB;
  localparam int unsigned EXT_W = (HI_W > NORM_W) ? HI_W : NORM_W;

  logic [HI_W-1:0]   hi;
  logic [EXT_W-1:0]  hi_ext, den_ext;

  div_ctl_t          ctl  [QB+1];
  logic [NORM_W-1:0] den  [QB+1];
  logic [NORM_W-1:0] rem  [QB+1];
  logic [QB-1:0]     low  [QB+1];
  logic [SIDE_W-1:0] side [QB+1];

  div_ctl_t          ctl0_q;
  logic [NORM_W-1:0] den0_q, rem0_q;
  logic [QB-1:0]     low0_q;
  logic [SIDE_W-1:0] side0_q;

  assign hi      = num_i[NUM_W-1:QB];
  assign hi_ext  = EXT_W'(hi);
  assign den_ext = EXT_W'(den_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl0_q <= '0;
    end else if (en_i) begin
      ctl0_q.valid <= valid_i;
      ctl0_q.ovf   <= hi_ext >= den_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den0_q  <= den_i;
      rem0_q  <= NORM_W'(hi);
      low0_q  <= num_i[QB-1:0];
      side0_q <= side_i;
    end
  end

  assign ctl[0]  = ctl0_q;
  assign den[0]  = den0_q;
  assign rem[0]  = rem0_q;
  assign low[0]  = low0_q;
  assign side[0] = side0_q;

  for (genvar k = 0; k < QB; k++) begin : g_cell
    rmj_div_cell #(
      .QB     (QB),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_i),
      .ctl_i  (ctl[k]),
      .den_i  (den[k]),
      .rem_i  (rem[k]),
      .low_i  (low[k]),
      .side_i (side[k]),
      .ctl_o  (ctl[k+1]),
      .den_o  (den[k+1]),
      .rem_o  (rem[k+1]),
      .low_o  (low[k+1]),
      .side_o (side[k+1])
    );
  end

  assign valid_o = ctl[QB].valid;
  assign ovf_o   = ctl[QB].ovf;
  assign quo_o   = low[QB];
  assign side_o  = side[QB];

endmodule

>>> design/rmj_sqrt_cell.sv
module rmj_sqrt_cell #(
  parameter int unsigned RT_W   = 17,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [RT_W:0]     rem_i,
  input  logic [RT_W-1:0]   root_i,
  input  logic [2*RT_W-1:0] xs_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [RT_W:0]     rem_o,
  output logic [RT_W-1:0]   root_o,
  output logic [2*RT_W-1:0] xs_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RT_W+2:0]   t, trial;
  logic              ge;
  logic              valid_q;
  logic [RT_W:0]     rem_d, rem_q;
  logic [RT_W-1:0]   root_d, root_q;
  logic [2*RT_W-1:0] xs_d, xs_q;
  logic [SIDE_W-1:0] side_q;

  assign t      = {rem_i, xs_i[2*RT_W-1 -: 2]};
  assign trial  = (RT_W+3)'({root_i, 2'b01});
  assign ge     = t >= trial;
  assign rem_d  = ge ? (RT_W+1)'(t - trial) : t[RT_W:0];
  assign root_d = {root_i[RT_W-2:0], ge};
  assign xs_d   = {xs_i[2*RT_W-3:0], 2'b00};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      xs_q   <= xs_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign xs_o    = xs_q;
  assign side_o  = side_q;

endmodule

>>> design/rmj_isqrt.sv
module rmj_isqrt #(
  parameter int unsigned X_W    = 33,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [X_W-1:0]             x_i,
  input  logic [SIDE_W-1:0]          side_i,
  output logic                       valid_o,
  output logic [(X_W+1)/2-1:0]       root_o,
  output logic [SIDE_W-1:0]          side_o
);

  localparam int unsigned RT_W = (X_W + 1) / 2;

  logic              vld  [RT_W+1];
  logic [RT_W:0]     rem  [RT_W+1];
  logic [RT_W-1:0]   root [RT_W+1];
  logic [2*RT_W-1:0] xs   [RT_W+1];
  logic [SIDE_W-1:0] side [RT_W+1];

  assign vld[0]  = valid_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign xs[0]   = (2*RT_W)'(x_i);
  assign side[0] = side_i;

  for (genvar k = 0; k < RT_W; k++) begin : g_cell
    rmj_sqrt_cell #(
      .RT_W   (RT_W),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[k]),
      .rem_i   (rem[k]),
      .root_i  (root[k]),
      .xs_i    (xs[k]),
      .side_i  (side[k]),
      .valid_o (vld[k+1]),
      .rem_o   (rem[k+1]),
      .root_o  (root[k+1]),
      .xs_o    (xs[k+1]),
      .side_o  (side[k+1])
    );
  end

  assign valid_o = vld[RT_W];
  assign root_o  = root[RT_W];
  assign side_o  = side[RT_W];

endmodule

>>> design/radar_measurement_jacobian_core.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  pos_x, pos_y, vel_x, vel_y
// m_axis    out  m_axis_tvalid / m_axis_tready  six jacobian entries, degenerate flag
// cfg       in   cfg_valid_i / cfg_ready_o      min_norm_squared
//
// one word per cycle while the output skid register is empty
// built from restoring divider cells, one quotient bit per cell,
// and square root cells, one root bit per cell
// reset clears all valid bits and loads min_norm_squared with 1
// the whole pipeline freezes only while the output skid register is full
module radar_measurement_jacobian_core import rmj_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [127:0]   s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [191:0]   m_axis_tdata,  // range_dx, range_dy, bearing_dx, bearing_dy, rate_dx, rate_dy
  output logic [0:0]     m_axis_tuser,  // degenerate
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned QX_W = 2*FRAC_BITS + 1;
  localparam int unsigned RT_W = FRAC_BITS + 1;
  localparam int unsigned XN_W = NORM_W + 2*FRAC_BITS;
  localparam int unsigned BN_W = WORD_W + 2*FRAC_BITS;
  localparam int unsigned RN_W = NORM_W + RT_W;
  localparam int unsigned PP_W = RT_W + WORD_W;
  localparam int unsigned SX_W = 2*WORD_W + 2*NORM_W + 3;
  localparam int unsigned SB_W = 2*RT_W + 1;
  localparam int unsigned OD_W = 6*WORD_W;

  logic en;
  logic [WORD_W-1:0] min_q;

  // stage 1
  logic v1_q;
  word_t px_q, py_q, vx_q, vy_q;
  // stage 2
  logic v2_q, sx2_q, sy2_q;
  word_t ax, ay, ax2_q, ay2_q;
  logic [NORM_W-1:0] aa2_q, bb2_q;
  logic signed [NORM_W-1:0] p1_d, p2_d, p1_q, p2_q;
  // stage 3
  logic v3_q, sx3_q, sy3_q, deg3_q, cneg3_q;
  logic [NORM_W-1:0] n_d, n3_q, aa3_q, bb3_q, cmag3_q;
  word_t ax3_q, ay3_q;
  // square norm divisions and roots
  logic [SX_W-1:0] sidx_in, sidx_dv, sidx_sq;
  logic vdx, vdy, odx, ody, vsx, vsy, degdy, degsy;
  logic [QX_W-1:0] qx, qy, xx, xy;
  logic [RT_W-1:0] rx, ry;
  word_t axs, ays;
  logic [NORM_W-1:0] ns, cms;
  logic sxs, sys, cns;
  // multiply stages
  logic vm1_q, vm2_q, sxm1_q, sym1_q, cnm1_q, dgm1_q, sxm2_q, sym2_q, cnm2_q, dgm2_q;
  logic [PP_W-1:0] pxl_q, pxh_q, pyl_q, pyh_q;
  logic [RT_W-1:0] rxm1_q, rym1_q, rxm2_q, rym2_q;
  word_t axm1_q, aym1_q, axm2_q, aym2_q;
  logic [NORM_W-1:0] nm1_q, nm2_q;
  logic [RN_W-1:0] numx_q, numy_q;
  // final divisions
  logic vbx, vby, vrx, vry, obx, oby, orx, ory, sxf, syf, cnf, dgf;
  word_t qbx, qby, qrx, qry;
  logic [SB_W-1:0] sbx;
  logic [RT_W-1:0] rxf, ryf;
  // pipe end and output skid
  logic pv_q, pdeg_q;
  logic [OD_W-1:0] pdata_d, pdata_q;
  logic out_v_q, out_v_d, sk_v_q, sk_v_d, out_u_q, sk_u_q;
  logic ld_out_pipe, ld_out_sk, ld_sk;
  logic [OD_W-1:0] out_d_q, sk_d_q;

  assign en            = !sk_v_q;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= WORD_W'(1);
    end else if (cfg_valid_i) begin
      min_q <= cfg_data_i;
    end
  end

  // valid bits of the stages outside the divider and root cells
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      vm1_q <= 1'b0;
      vm2_q <= 1'b0;
      pv_q  <= 1'b0;
    end else if (en) begin
      v1_q  <= s_axis_tvalid;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      vm1_q <= vsx & vsy;
      vm2_q <= vm1_q;
      pv_q  <= vbx & vby & vrx & vry;
    end
  end

  assign ax   = px_q[WORD_W-1] ? -px_q : px_q;
  assign ay   = py_q[WORD_W-1] ? -py_q : py_q;
  assign p1_d = $signed(vx_q) * $signed(py_q);
  assign p2_d = $signed(vy_q) * $signed(px_q);
  assign n_d  = aa2_q + bb2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_q    <= s_axis_tdata[31:0];
      py_q    <= s_axis_tdata[63:32];
      vx_q    <= s_axis_tdata[95:64];
      vy_q    <= s_axis_tdata[127:96];

      aa2_q   <= ax * ax;
      bb2_q   <= ay * ay;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      ax2_q   <= ax;
      ay2_q   <= ay;
      sx2_q   <= px_q[WORD_W-1];
      sy2_q   <= py_q[WORD_W-1];

      n3_q    <= n_d;
      deg3_q  <= (n_d < NORM_W'(min_q)) || (n_d == '0);
      cneg3_q <= p1_q < p2_q;
      cmag3_q <= (p1_q < p2_q) ? NORM_W'(p2_q - p1_q) : NORM_W'(p1_q - p2_q);
      aa3_q   <= aa2_q;
      bb3_q   <= bb2_q;
      ax3_q   <= ax2_q;
      ay3_q   <= ay2_q;
      sx3_q   <= sx2_q;
      sy3_q   <= sy2_q;
    end
  end

  assign sidx_in = {ax3_q, ay3_q, n3_q, cmag3_q, sx3_q, sy3_q, cneg3_q};

  rmj_divider #(.NUM_W(XN_W), .QB(QX_W), .SIDE_W(SX_W)) u_div_nx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v3_q),
    .num_i ({aa3_q, {(2*FRAC_BITS){1'b0}}}), .den_i (n3_q), .side_i (sidx_in),
    .valid_o (vdx), .ovf_o (odx), .quo_o (qx), .side_o (sidx_dv)
  );

  rmj_divider #(.NUM_W(XN_W), .QB(QX_W), .SIDE_W(1)) u_div_ny (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (v3_q),
    .num_i ({bb3_q, {(2*FRAC_BITS){1'b0}}}), .den_i (n3_q), .side_i (deg3_q),
    .valid_o (vdy), .ovf_o (ody), .quo_o (qy), .side_o (degdy)
  );

  assign xx = odx ? '1 : qx;
  assign xy = ody ? '1 : qy;

  rmj_isqrt #(.X_W(QX_W), .SIDE_W(SX_W)) u_sqrt_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vdx),
    .x_i (xx), .side_i (sidx_dv), .valid_o (vsx), .root_o (rx), .side_o (sidx_sq)
  );

  rmj_isqrt #(.X_W(QX_W), .SIDE_W(1)) u_sqrt_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vdy),
    .x_i (xy), .side_i (degdy), .valid_o (vsy), .root_o (ry), .side_o (degsy)
  );

  assign {axs, ays, ns, cms, sxs, sys, cns} = sidx_sq;

  // range rate numerators, split into two partial products
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q  <= rx * cms[WORD_W-1:0];
      pxh_q  <= rx * cms[NORM_W-1:WORD_W];
      pyl_q  <= ry * cms[WORD_W-1:0];
      pyh_q  <= ry * cms[NORM_W-1:WORD_W];
      rxm1_q <= rx;
      rym1_q <= ry;
      axm1_q <= axs;
      aym1_q <= ays;
      nm1_q  <= ns;
      sxm1_q <= sxs;
      sym1_q <= sys;
      cnm1_q <= cns;
      dgm1_q <= degsy;

      numx_q <= {pxh_q, {WORD_W{1'b0}}} + RN_W'(pxl_q);
      numy_q <= {pyh_q, {WORD_W{1'b0}}} + RN_W'(pyl_q);
      rxm2_q <= rxm1_q;
      rym2_q <= rym1_q;
      axm2_q <= axm1_q;
      aym2_q <= aym1_q;
      nm2_q  <= nm1_q;
      sxm2_q <= sxm1_q;
      sym2_q <= sym1_q;
      cnm2_q <= cnm1_q;
      dgm2_q <= dgm1_q;
    end
  end

  rmj_divider #(.NUM_W(BN_W), .QB(WORD_W), .SIDE_W(SB_W)) u_div_bx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vm2_q),
    .num_i ({axm2_q, {(2*FRAC_BITS){1'b0}}}), .den_i (nm2_q),
    .side_i ({rxm2_q, rym2_q, sxm2_q}),
    .valid_o (vbx), .ovf_o (obx), .quo_o (qbx), .side_o (sbx)
  );

  rmj_divider #(.NUM_W(BN_W), .QB(WORD_W), .SIDE_W(1)) u_div_by (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vm2_q),
    .num_i ({aym2_q, {(2*FRAC_BITS){1'b0}}}), .den_i (nm2_q), .side_i (sym2_q),
    .valid_o (vby), .ovf_o (oby), .quo_o (qby), .side_o (syf)
  );

  rmj_divider #(.NUM_W(RN_W), .QB(WORD_W), .SIDE_W(1)) u_div_rx (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vm2_q),
    .num_i (numy_q), .den_i (nm2_q), .side_i (cnm2_q),
    .valid_o (vrx), .ovf_o (orx), .quo_o (qrx), .side_o (cnf)
  );

  rmj_divider #(.NUM_W(RN_W), .QB(WORD_W), .SIDE_W(1)) u_div_ry (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en), .valid_i (vm2_q),
    .num_i (numx_q), .den_i (nm2_q), .side_i (dgm2_q),
    .valid_o (vry), .ovf_o (ory), .quo_o (qry), .side_o (dgf)
  );

  assign {rxf, ryf, sxf} = sbx;

  always_comb begin
    pdata_d = '0;
    if (!dgf) begin
      pdata_d = {sat_word(qry, ory, !(sxf ^ cnf)),
                 sat_word(qrx, orx, syf ^ cnf),
                 sat_word(qbx, obx, sxf),
                 sat_word(qby, oby, !syf),
                 sat_word(WORD_W'(ryf), 1'b0, syf),
                 sat_word(WORD_W'(rxf), 1'b0, sxf)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdata_q <= pdata_d;
      pdeg_q  <= dgf;
    end
  end

  // output register with skid stage
  always_comb begin
    out_v_d     = out_v_q;
    sk_v_d      = sk_v_q;
    ld_out_pipe = 1'b0;
    ld_out_sk   = 1'b0;
    ld_sk       = 1'b0;
    if (!out_v_q || m_axis_tready) begin
      if (sk_v_q) begin
        out_v_d   = 1'b1;
        sk_v_d    = 1'b0;
        ld_out_sk = 1'b1;
      end else begin
        out_v_d     = pv_q;
        ld_out_pipe = pv_q;
      end
    end else if (pv_q && en) begin
      sk_v_d = 1'b1;
      ld_sk  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      sk_v_q  <= sk_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out_sk) begin
      out_d_q <= sk_d_q;
      out_u_q <= sk_u_q;
    end else if (ld_out_pipe) begin
      out_d_q <= pdata_q;
      out_u_q <= pdeg_q;
    end
    if (ld_sk) begin
      sk_d_q <= pdata_q;
      sk_u_q <= pdeg_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;

endmodule

>>> design/rmj_checker.sv
`include "radar_measurement_jacobian_core_defines.svh"

module rmj_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [0:0]   m_axis_tuser,
  input logic         cfg_valid_i,
  input logic         cfg_ready_o
);

  `RMJ_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `RMJ_ASSERT_IMP(a_deg_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `RMJ_ASSERT_IMP(a_bear_sign, m_axis_tvalid && m_axis_tdata[31], m_axis_tdata[127] || m_axis_tdata[127:96] == '0)
  `RMJ_ASSERT_IMP(a_skid_full, !s_axis_tready, m_axis_tvalid)
  `RMJ_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_o)

endmodule

bind radar_measurement_jacobian_core rmj_checker u_rmj_checker (.*);

>>> tb/sv/tb_radar_measurement_jacobian_core.sv
`timescale 1ns / 1ps

module tb_radar_measurement_jacobian_core;
  import rmj_pkg::*;

  localparam int unsigned LATENCY = 91;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 110;
  localparam logic [63:0] QUOT_CAP = 64'd1 << 50;

  typedef struct packed {
    logic        degenerate;
    logic [31:0] rate_dy;
    logic [31:0] rate_dx;
    logic [31:0] bearing_dy;
    logic [31:0] bearing_dx;
    logic [31:0] range_dy;
    logic [31:0] range_dx;
  } jacobian_t;

  typedef struct {
    logic [31:0] pos_x, pos_y, vel_x, vel_y;
    logic        typed;
    jacobian_t   jac;
  } track_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_axis_tvalid = 1'b0;
  logic           s_axis_tready;
  logic [127:0]   s_axis_tdata = '0;
  logic           m_axis_tvalid;
  logic           m_axis_tready = 1'b0;
  logic [191:0]   m_axis_tdata;
  logic [0:0]     m_axis_tuser;
  logic           cfg_valid_i = 1'b0;
  logic           cfg_ready_o;
  logic [31:0]    cfg_data_i = '0;

  logic [31:0] norm_floor = 32'd1;
  jacobian_t   jac_pending[$];
  int          err_count = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  radar_measurement_jacobian_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] capped_div(logic [127:0] num, logic [63:0] d);
    logic [127:0] q;
    q = num / {64'd0, d};
    return (q > {64'd0, QUOT_CAP}) ? QUOT_CAP : q[63:0];
  endfunction

  function automatic logic [31:0] clamp_q(logic [63:0] mag, logic neg);
    logic [63:0] m;
    if (neg) begin
      m = (mag > 64'h8000_0000) ? 64'h8000_0000 : mag;
      m = -m;
      return m[31:0];
    end
    return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
  endfunction

  function automatic jacobian_t predict_jacobian(logic [127:0] w);
    logic signed [63:0] px, py, vx, vy;
    logic [63:0]        ax, ay, n, rx, ry, bx, by;
    logic signed [65:0] c;
    logic [65:0]        cmag;
    logic               cneg;
    logic [127:0]       t;
    jacobian_t          j;
    px = $signed(w[31:0]);
    py = $signed(w[63:32]);
    vx = $signed(w[95:64]);
    vy = $signed(w[127:96]);
    ax = (px < 0) ? -px : px;
    ay = (py < 0) ? -py : py;
    n = ax * ax + ay * ay;
    j = '0;
    if (n < {32'd0, norm_floor} || n == 0) begin
      j.degenerate = 1'b1;
      return j;
    end
    t = {64'd0, ax} * {64'd0, ax};
    rx = int_sqrt(capped_div(t << 32, n));
    t = {64'd0, ay} * {64'd0, ay};
    ry = int_sqrt(capped_div(t << 32, n));
    by = capped_div({64'd0, ay} << 32, n);
    bx = capped_div({64'd0, ax} << 32, n);
    c = vx * py - vy * px;
    cneg = c < 0;
    cmag = cneg ? -c : c;
    j.range_dx = clamp_q(rx, px < 0);
    j.range_dy = clamp_q(ry, py < 0);
    j.bearing_dx = clamp_q(by, py > 0);
    j.bearing_dy = clamp_q(bx, px < 0);
    j.rate_dx = clamp_q(capped_div({64'd0, ry} * {62'd0, cmag}, n), (py < 0) != cneg);
    j.rate_dy = clamp_q(capped_div({64'd0, rx} * {62'd0, cmag}, n), (px < 0) == cneg);
    return j;
  endfunction

  function automatic logic [31:0] rand_field();
    logic [31:0] v;
    case ($urandom_range(0, 4))
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h3_FFFF);
      2: v = $urandom_range(0, 255);
      3: begin
        case ($urandom_range(0, 4))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          3: v = 32'd1;
          default: v = 32'd0;
        endcase
      end
      default: v = $urandom_range(0, 32'hFF_FFFF);
    endcase
    if ($urandom_range(0, 1) && !(v inside {32'h8000_0000, 32'h7FFF_FFFF})) v = -v;
    return v;
  endfunction

  // drive one track word and record its expectation when it is taken
  task automatic send_track(logic [127:0] w, logic typed, jacobian_t jac);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    jac_pending.push_back(typed ? jac : predict_jacobian(w));
    @(negedge clk_i);
  endtask

  task automatic write_floor(logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    while (jac_pending.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 10) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    norm_floor = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always begin
    @(negedge clk_i);
    if (hold_req) begin
      m_axis_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk_i);
      hold_req = 1'b0;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    jacobian_t act, exp_j;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act = {m_axis_tuser, m_axis_tdata};
      if (jac_pending.size() == 0) begin
        $error("unexpected word: %h", act);
        err_count++;
      end else begin
        exp_j = jac_pending.pop_front();
        if (act.range_dx !== exp_j.range_dx) begin
          $error("range_dx exp %h got %h", exp_j.range_dx, act.range_dx); err_count++;
        end
        if (act.range_dy !== exp_j.range_dy) begin
          $error("range_dy exp %h got %h", exp_j.range_dy, act.range_dy); err_count++;
        end
        if (act.bearing_dx !== exp_j.bearing_dx) begin
          $error("bearing_dx exp %h got %h", exp_j.bearing_dx, act.bearing_dx); err_count++;
        end
        if (act.bearing_dy !== exp_j.bearing_dy) begin
          $error("bearing_dy exp %h got %h", exp_j.bearing_dy, act.bearing_dy); err_count++;
        end
        if (act.rate_dx !== exp_j.rate_dx) begin
          $error("rate_dx exp %h got %h", exp_j.rate_dx, act.rate_dx); err_count++;
        end
        if (act.rate_dy !== exp_j.rate_dy) begin
          $error("rate_dy exp %h got %h", exp_j.rate_dy, act.rate_dy); err_count++;
        end
        if (act.degenerate !== exp_j.degenerate) begin
          $error("degenerate exp %b got %b", exp_j.degenerate, act.degenerate); err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    track_row_t  rows[$];
    track_row_t  r;
    logic [31:0] floors[5];
    jacobian_t   none;
    none = '0;
    floors = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'd1, 32'h0000_0100};

    // zero state, unit and raw-lsb positions, extremes
    r = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{1'b1, 0, 0, 0, 0, 0, 0}};
    rows.push_back(r);
    r = '{32'h0001_0000, 32'd0, 32'd0, 32'd0, 1'b1,
          '{1'b0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000}};
    rows.push_back(r);
    r = '{32'hFFFF_0000, 32'd0, 32'd0, 32'd0, 1'b1,
          '{1'b0, 0, 0, 32'hFFFF_0000, 0, 0, 32'hFFFF_0000}};
    rows.push_back(r);
    r = '{32'd0, 32'h0001_0000, 32'd0, 32'd0, 1'b1,
          '{1'b0, 0, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 0}};
    rows.push_back(r);
    r = '{32'd1, 32'd0, 32'd0, 32'd0, 1'b1,
          '{1'b0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h0001_0000}};
    rows.push_back(r);
    r = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, none};
    rows.push_back(r);
    r = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, none};
    rows.push_back(r);
    r = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, none};
    rows.push_back(r);
    r = '{32'd1, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, none};
    rows.push_back(r);
    r = '{32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, none};
    rows.push_back(r);
    r = '{32'h0003_0000, 32'hFFFC_0000, 32'h0000_8000, 32'hFFFE_0000, 1'b0, none};
    rows.push_back(r);
    r = '{32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, none};
    rows.push_back(r);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      send_track({rows[i].vel_y, rows[i].vel_x, rows[i].pos_y, rows[i].pos_x},
                 rows[i].typed, rows[i].jac);
    end

    for (int ph = 0; ph < 5; ph++) begin
      write_floor(ph == 2 ? $urandom : floors[ph]);
      if (ph == 1) hold_req = 1'b1;
      if (ph == 4) quiet = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_track({rand_field(), rand_field(), rand_field(), rand_field()}, 1'b0, none);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (jac_pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
